@@ rtl/crcfd_pkg.sv @@
`default_nettype none
package crcfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int MAX_FRAME_DEF   = 41;

    localparam int HDR_BYTES = 7;
    localparam int CRC_BYTES = 2;

    // header byte positions
    localparam int POS_VER    = 2;
    localparam int POS_TYPE   = 3;
    localparam int POS_LEN    = 4;
    localparam int POS_SEQ_LO = 5;
    localparam int POS_SEQ_HI = 6;

    localparam int BYTE_BITS = 8;
    localparam int STEP_W    = $clog2(BYTE_BITS);
    localparam int CRC_W     = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 2'd2;

    localparam logic [7:0] START_ONE_RST = 8'd165;
    localparam logic [7:0] START_TWO_RST = 8'd90;
    localparam logic [7:0] VERSION_RST   = 8'd1;

    // output word layout
    localparam int OUT_TYPE_LSB  = 0;
    localparam int OUT_LEN_LSB   = 8;
    localparam int OUT_SEQ_LSB   = 14;
    localparam int OUT_BYTE_LSB  = 30;
    localparam int OUT_INDEX_LSB = 38;
    localparam int OUT_USED_W    = 43;
    localparam int OUT_TDATA_W   = 48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_RD,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic       start;
        logic       seed;
        logic       clear;
        logic [7:0] data;
    } t_crc_cmd;

endpackage
`default_nettype wire

@@ rtl/crcfd_ram.sv @@
`default_nettype none
module crcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/crcfd_crc.sv @@
`default_nettype none
module crcfd_crc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  crcfd_pkg::t_crc_cmd          i_cmd,
    output logic [crcfd_pkg::CRC_W-1:0]  o_crc,
    output logic                         o_busy
);
    import crcfd_pkg::*;

    logic [CRC_W-1:0]  r_crc, n_crc;
    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_crc  = r_crc;
        n_busy = r_busy;
        n_step = r_step;
        if (i_cmd.clear) begin
            n_crc  = CRC_INIT;
            n_busy = 1'b0;
        end else if (i_cmd.start) begin
            n_crc  = (i_cmd.seed ? CRC_INIT : r_crc) ^ {i_cmd.data, 8'h00};
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            // one bit of the byte per cycle
            n_crc  = r_crc[CRC_W-1] ? ({r_crc[CRC_W-2:0], 1'b0} ^ CRC_POLY)
                                    : {r_crc[CRC_W-2:0], 1'b0};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(BYTE_BITS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_crc  <= n_crc;
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

@@ rtl/crc16_framed_packet_deframer.sv @@
// Byte-stream frame parser: takes one received byte per input word, hunts for
// start one/start two/version/type/length/sequence(LE)/payload/CRC(LE) frames
// and checks a CRC-16/CCITT-FALSE over every byte before the CRC. A byte that
// enters the CRC is accepted and shifted bit by bit through the bit-serial CRC
// shift register before the parser returns to idle; a dropped byte or a CRC
// byte does not wait on it. After the final CRC byte of a good frame the payload
// is read back from the frame buffer and sent as one output word per byte (one
// header-only word for an empty payload), tlast on the final one: each word is
// read through the buffer's registered read port, then loaded once the output
// register is free, while s_axis_tready is low. The output register holds a
// finished word while the next byte is taken. No clearing pass after reset.
`default_nettype none
module crc16_framed_packet_deframer #(
    parameter int MAX_PAYLOAD = crcfd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_FRAME   = crcfd_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crcfd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [7:0]                          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // msg_kind[7:0], pay_len[13:8], sequence_number[29:14],
    // payload_byte[37:30], byte_index[42:38], zero pad[47:43]
    output logic [crcfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]                          m_axis_tuser,   // payload_valid
    output logic                                m_axis_tlast    // last_of_frame
);
    import crcfd_pkg::*;

    localparam int FL_MAX = (MAX_FRAME > MAX_PAYLOAD + HDR_BYTES + CRC_BYTES) ?
                            MAX_FRAME : MAX_PAYLOAD + HDR_BYTES + CRC_BYTES;
    localparam int CW = $clog2(FL_MAX + 1);
    localparam int AW = $clog2(MAX_FRAME);
    localparam int IW = $clog2(MAX_PAYLOAD + 1);

    t_state r_state, n_state;

    logic [7:0]    r_sb1, r_sb2, r_ver;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_flen, n_flen;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_prev;
    logic [7:0]    r_type;
    logic [IW-1:0] r_plen;
    logic [15:0]   r_seq;

    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic                   r_ouser;
    logic                   r_olast;

    logic [7:0]       rx;
    logic             in_acc;
    logic             out_free;
    logic             load_out;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic [AW-1:0]    ram_raddr;
    t_crc_cmd         crc_cmd;
    logic [CRC_W-1:0] crc_val;
    logic             crc_busy;

    logic          d_restart, d_store, d_feed, d_emit, d_keep;
    logic [CW-1:0] cnt_inc, flen_nx;
    logic          e_last;
    logic [7:0]    e_byte;
    logic [4:0]    e_index;

    assign rx       = s_axis_tdata;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign d_keep   = (rx == r_sb1);
    assign cnt_inc  = r_cnt + CW'(1);

    // per-byte decision
    always_comb begin
        d_restart = 1'b0;
        d_store   = 1'b0;
        d_feed    = 1'b0;
        d_emit    = 1'b0;
        flen_nx   = r_flen;
        if (r_cnt == '0) begin
            d_restart = 1'b1;
        end else if (r_cnt == CW'(1)) begin
            if (rx != r_sb2) begin
                d_restart = 1'b1;
            end else begin
                d_store = 1'b1;
                d_feed  = 1'b1;
            end
        end else if (r_cnt >= CW'(MAX_FRAME)) begin
            d_restart = 1'b1;
        end else begin
            d_store = 1'b1;
            d_feed  = (r_flen == '0) || (r_cnt < r_flen - CW'(CRC_BYTES));
            if (r_cnt == CW'(POS_VER) && rx != r_ver) begin
                d_restart = 1'b1;
            end else if (r_cnt == CW'(POS_LEN) && rx > 8'(MAX_PAYLOAD)) begin
                d_restart = 1'b1;
            end else begin
                if (r_cnt == CW'(POS_LEN)) begin
                    flen_nx = CW'(HDR_BYTES + CRC_BYTES) + CW'(rx);
                end
                if (flen_nx != '0 && cnt_inc >= flen_nx) begin
                    if (cnt_inc != flen_nx) begin
                        d_restart = 1'b1;
                    end else if ({rx, r_prev} != crc_val) begin
                        d_restart = 1'b1;
                    end else begin
                        d_emit = 1'b1;
                    end
                end
            end
        end
    end

    assign e_last    = (r_plen == '0) || (IW'(r_idx + IW'(1)) == r_plen);
    assign e_byte    = (r_plen == '0) ? 8'd0 : ram_rdata;
    assign e_index   = (r_plen == '0) ? 5'd0 : 5'(r_idx);
    assign ram_raddr = AW'(HDR_BYTES) + AW'(r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (d_emit) begin
                        n_state = S_RD;
                    end else if (crc_cmd.start) begin
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (!crc_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = e_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        load_out      = 1'b0;
        crc_cmd       = '0;
        crc_cmd.data  = rx;
        n_cnt         = r_cnt;
        n_flen        = r_flen;
        n_idx         = r_idx;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    ram_we = d_store;
                    if (d_emit) begin
                        crc_cmd.clear = 1'b1;
                        n_cnt         = '0;
                        n_flen        = '0;
                        n_idx         = '0;
                    end else if (d_restart) begin
                        crc_cmd.start = d_keep;
                        crc_cmd.seed  = 1'b1;
                        crc_cmd.clear = !d_keep;
                        n_cnt         = d_keep ? CW'(1) : '0;
                        n_flen        = '0;
                    end else begin
                        crc_cmd.start = d_feed;
                        n_cnt         = cnt_inc;
                        n_flen        = flen_nx;
                    end
                end
            end
            S_LOAD: begin
                load_out = out_free;
                if (out_free && !e_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_flen   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_sb1    <= START_ONE_RST;
            r_sb2    <= START_TWO_RST;
            r_ver    <= VERSION_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_flen  <= n_flen;
            r_idx   <= n_idx;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_ONE: r_sb1 <= i_cfg_wdata;
                    CFG_START_TWO: r_sb2 <= i_cfg_wdata;
                    CFG_VERSION:   r_ver <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && d_store) begin
            r_prev <= rx;
            if (r_cnt == CW'(POS_TYPE)) begin
                r_type <= rx;
            end
            if (r_cnt == CW'(POS_LEN)) begin
                r_plen <= IW'(rx);
            end
            if (r_cnt == CW'(POS_SEQ_LO)) begin
                r_seq[7:0] <= rx;
            end
            if (r_cnt == CW'(POS_SEQ_HI)) begin
                r_seq[15:8] <= rx;
            end
        end
        if (load_out) begin
            r_odata <= {(OUT_TDATA_W - OUT_USED_W)'(0), e_index, e_byte, r_seq,
                        6'(r_plen), r_type};
            r_ouser <= (r_plen != '0);
            r_olast <= e_last;
        end
    end

    crcfd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_crc   (crc_val),
        .o_busy  (crc_busy)
    );

    crcfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (rx),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule
`default_nettype wire

@@ rtl/crcfd_checker.sv @@
`default_nettype none
module crcfd_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [crcfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]                        m_axis_tuser,
    input wire logic                              m_axis_tlast
);
    import crcfd_pkg::*;

    a_rst_no_word: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a payload run is still going out");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast
            && m_axis_tdata[OUT_BYTE_LSB +: 8] == 8'd0
            && m_axis_tdata[OUT_LEN_LSB +: 6] == 6'd0
            && m_axis_tdata[OUT_INDEX_LSB +: 5] == 5'd0)
        else $error("header-only word malformed");

endmodule

bind crc16_framed_packet_deframer crcfd_checker u_crcfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
